// ===== design/msrd_pkg.sv =====
// Shared types and constants for the motor speed ramp driver.
// No dependencies; used by msrd_div and motor_speed_ramp_driver.
`default_nettype none

package msrd_pkg;

    localparam int SPEED_BITS   = 8;
    localparam int PERIOD_BITS  = 15;
    localparam int ELAPSED_BITS = 16;
    localparam int HOLD_BITS    = 10;
    localparam int DIV_CNT_BITS = $clog2(PERIOD_BITS + 1);

    localparam logic [HOLD_BITS-1:0] HOLD_OFF_US = 10'd600;
    localparam logic [HOLD_BITS-1:0] HOLD_ON_US  = 10'd300;
    localparam logic [HOLD_BITS-1:0] HOLD_NONE   = 10'd0;

    localparam logic [SPEED_BITS-1:0] MAX_SPEED_RST = '1;
    localparam logic [SPEED_BITS-1:0] MIN_SPEED_RST = '0;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SPEED = 2'd1,
        ACT_DIR   = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic {
        CFG_MAX_SPEED = 1'b0,
        CFG_MIN_SPEED = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_APPLY,
        S_EMIT0,
        S_EMIT1
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [PERIOD_BITS-1:0] dividend;
        logic [SPEED_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [PERIOD_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== design/msrd_div.sv =====
// Restoring serial divider for the ramp step period, one quotient bit per cycle.
// Depends on msrd_pkg.
`default_nettype none

module msrd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire msrd_pkg::t_div_req i_req,
    output msrd_pkg::t_div_rsp     o_rsp
);

    logic                                 r_busy, n_busy;
    logic [msrd_pkg::DIV_CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [msrd_pkg::SPEED_BITS-1:0]      r_rem, n_rem;
    logic [msrd_pkg::SPEED_BITS-1:0]      r_div, n_div;
    logic [msrd_pkg::PERIOD_BITS-1:0]     r_quo, n_quo;
    logic [msrd_pkg::SPEED_BITS:0]        w_shift;
    logic [msrd_pkg::SPEED_BITS:0]        w_diff;
    logic                                 w_ge;

    assign w_shift = {r_rem, r_quo[msrd_pkg::PERIOD_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = msrd_pkg::DIV_CNT_BITS'(msrd_pkg::PERIOD_BITS);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                n_rem = w_ge ? w_diff[msrd_pkg::SPEED_BITS-1:0]
                             : w_shift[msrd_pkg::SPEED_BITS-1:0];
                n_quo = {r_quo[msrd_pkg::PERIOD_BITS-2:0], w_ge};
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/motor_speed_ramp_driver.sv =====
// Channel   Handshake                   Payload
// in        i_in_valid / o_in_ready     i_action, i_target_speed, i_ramp_duration,
//                                       i_start_speed, i_dir_request
// out       o_out_valid / i_out_ready   o_pwm_duty, o_bridge_pin_a, o_bridge_pin_b,
//                                       o_enable_pin, o_ramping, o_hold_us, o_last
// cfg       i_cfg_we                    i_cfg_index, i_cfg_data
//
// One transaction at a time: a tick or sharp set-speed passes DECIDE, APPLY and EMIT1
// before the next ready, a repeated direction or unused action EMIT1 only, a direction
// change EMIT0 then EMIT1; a set-speed with positive duration and a nonzero distance adds
// DIV after DECIDE, in the serial divider (15 quotient bits, one per cycle, then done).
// A waiting result holds the emit state for as long as the output is stalled.
// Reset is synchronous, active low: speed, duty, ramp, pins and motor status clear (enable high on the next result).
// Depends on msrd_pkg and msrd_div.
`default_nettype none

module motor_speed_ramp_driver (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [1:0]                             i_action,
    input  wire logic signed [15:0]                     i_target_speed,
    input  wire logic signed [15:0]                     i_ramp_duration,
    input  wire logic signed [8:0]                      i_start_speed,
    input  wire logic                                   i_dir_request,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [msrd_pkg::SPEED_BITS-1:0]             o_pwm_duty,
    output logic                                        o_bridge_pin_a,
    output logic                                        o_bridge_pin_b,
    output logic                                        o_enable_pin,
    output logic                                        o_ramping,
    output logic [msrd_pkg::HOLD_BITS-1:0]              o_hold_us,
    output logic                                        o_last,
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_index,
    input  wire logic [msrd_pkg::SPEED_BITS-1:0]        i_cfg_data
);

    msrd_pkg::t_state                       r_state, n_state;
    msrd_pkg::t_action                      w_action;

    logic [msrd_pkg::SPEED_BITS-1:0]        r_max_speed, r_min_speed;

    logic [msrd_pkg::SPEED_BITS-1:0]        r_cur, n_cur;
    logic [msrd_pkg::SPEED_BITS-1:0]        r_tgt, n_tgt;
    logic [msrd_pkg::PERIOD_BITS-1:0]       r_period, n_period;
    logic [msrd_pkg::ELAPSED_BITS-1:0]      r_elapsed, n_elapsed;
    logic                                   r_ramp, n_ramp;
    logic                                   r_motor, n_motor;
    logic                                   r_dir, n_dir;
    logic                                   r_dir_known, n_dir_known;
    logic [msrd_pkg::SPEED_BITS-1:0]        r_duty, n_duty;
    logic                                   r_pin_a, n_pin_a;
    logic                                   r_pin_b, n_pin_b;

    logic [msrd_pkg::SPEED_BITS-1:0]        r_to, n_to;
    logic [msrd_pkg::SPEED_BITS-1:0]        r_from, n_from;
    logic [msrd_pkg::PERIOD_BITS-1:0]       r_dividend, n_dividend;
    logic                                   r_apply, n_apply;
    logic                                   r_dur_pos, n_dur_pos;
    logic                                   r_dur_neg, n_dur_neg;
    logic                                   r_is_tick, n_is_tick;
    logic                                   r_dir_req, n_dir_req;
    logic                                   r_dir_chg, n_dir_chg;

    logic                                   r_out_valid;
    logic [msrd_pkg::SPEED_BITS-1:0]        r_o_duty;
    logic                                   r_o_pin_a, r_o_pin_b, r_o_en, r_o_ramp, r_o_last;
    logic [msrd_pkg::HOLD_BITS-1:0]         r_o_hold;

    logic                                   w_in_acc;
    logic                                   w_slot_free;
    logic                                   w_out_load;
    logic                                   w_last;
    logic [msrd_pkg::HOLD_BITS-1:0]         w_hold;
    logic [msrd_pkg::SPEED_BITS-1:0]        w_tgt_clamp;
    logic [msrd_pkg::SPEED_BITS-1:0]        w_from_in;
    logic [msrd_pkg::ELAPSED_BITS-1:0]      w_elapsed_inc;
    logic                                   w_step;
    logic [msrd_pkg::SPEED_BITS-1:0]        w_s;
    logic [msrd_pkg::SPEED_BITS-1:0]        w_s_clamp;
    logic                                   w_dir_chg;
    logic [msrd_pkg::SPEED_BITS-1:0]        w_dist;
    logic                                   w_div_need;
    msrd_pkg::t_div_req                     w_div_req;
    msrd_pkg::t_div_rsp                     w_div_rsp;

    assign w_action    = msrd_pkg::t_action'(i_action);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= msrd_pkg::MAX_SPEED_RST;
            r_min_speed <= msrd_pkg::MIN_SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (msrd_pkg::t_cfg_index'(i_cfg_index))
                msrd_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_data[msrd_pkg::SPEED_BITS-1:0];
                msrd_pkg::CFG_MIN_SPEED: r_min_speed <= i_cfg_data[msrd_pkg::SPEED_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        if (i_target_speed > $signed({1'b0, r_max_speed})) begin
            w_tgt_clamp = r_max_speed;
        end else if (i_target_speed[15]) begin
            w_tgt_clamp = r_min_speed;
        end else begin
            w_tgt_clamp = i_target_speed[msrd_pkg::SPEED_BITS-1:0];
        end
        w_from_in = i_start_speed[8] ? r_cur : i_start_speed[msrd_pkg::SPEED_BITS-1:0];
        w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
        w_step = r_ramp && (w_elapsed_inc >= {1'b0, r_period});
        if (r_tgt > r_cur) begin
            w_s = r_cur + 1'b1;
        end else if (r_tgt < r_cur) begin
            w_s = r_cur - 1'b1;
        end else begin
            w_s = r_cur;
        end
        w_s_clamp  = (w_s > r_max_speed) ? r_max_speed : w_s;
        w_dir_chg  = !r_dir_known || (r_dir != i_dir_request);
        w_dist     = (r_to > r_from) ? r_to - r_from : r_from - r_to;
        w_div_need = r_apply && r_dur_pos && (w_dist != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msrd_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_action) inside
                        msrd_pkg::ACT_TICK, msrd_pkg::ACT_SPEED: n_state = msrd_pkg::S_DECIDE;
                        msrd_pkg::ACT_DIR: n_state = w_dir_chg ? msrd_pkg::S_EMIT0
                                                               : msrd_pkg::S_EMIT1;
                        msrd_pkg::ACT_NOP: n_state = msrd_pkg::S_EMIT1;
                    endcase
                end
            end
            msrd_pkg::S_DECIDE: n_state = w_div_need ? msrd_pkg::S_DIV : msrd_pkg::S_APPLY;
            msrd_pkg::S_DIV:    if (w_div_rsp.done) n_state = msrd_pkg::S_APPLY;
            msrd_pkg::S_APPLY:  n_state = msrd_pkg::S_EMIT1;
            msrd_pkg::S_EMIT0:  if (w_slot_free) n_state = msrd_pkg::S_EMIT1;
            msrd_pkg::S_EMIT1:  if (w_slot_free) n_state = msrd_pkg::S_IDLE;
            default:            n_state = msrd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_last     = 1'b1;
        w_hold     = msrd_pkg::HOLD_NONE;
        unique case (r_state)
            msrd_pkg::S_IDLE: o_in_ready = 1'b1;
            msrd_pkg::S_EMIT0: begin
                w_out_load = w_slot_free;
                w_last     = 1'b0;
                w_hold     = msrd_pkg::HOLD_OFF_US;
            end
            msrd_pkg::S_EMIT1: begin
                w_out_load = w_slot_free;
                w_hold     = r_dir_chg ? msrd_pkg::HOLD_ON_US : msrd_pkg::HOLD_NONE;
            end
            default: ;
        endcase
        w_div_req.start    = (r_state == msrd_pkg::S_DECIDE) && w_div_need;
        w_div_req.dividend = r_dividend;
        w_div_req.divisor  = w_dist;
    end

    always_comb begin
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_period    = r_period;
        n_elapsed   = r_elapsed;
        n_ramp      = r_ramp;
        n_motor     = r_motor;
        n_dir       = r_dir;
        n_dir_known = r_dir_known;
        n_duty      = r_duty;
        n_pin_a     = r_pin_a;
        n_pin_b     = r_pin_b;
        n_to        = r_to;
        n_from      = r_from;
        n_dividend  = r_dividend;
        n_apply     = r_apply;
        n_dur_pos   = r_dur_pos;
        n_dur_neg   = r_dur_neg;
        n_is_tick   = r_is_tick;
        n_dir_req   = r_dir_req;
        n_dir_chg   = r_dir_chg;
        unique case (r_state)
            msrd_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_dir_req  = i_dir_request;
                    n_dir_chg  = 1'b0;
                    n_dividend = i_ramp_duration[msrd_pkg::PERIOD_BITS-1:0];
                    unique case (w_action)
                        msrd_pkg::ACT_TICK: begin
                            n_elapsed = w_step ? '0 : w_elapsed_inc;
                            n_apply   = w_step;
                            n_to      = w_s_clamp;
                            n_from    = r_cur;
                            n_dur_pos = 1'b0;
                            n_dur_neg = 1'b1;
                            n_is_tick = 1'b1;
                        end
                        msrd_pkg::ACT_SPEED: begin
                            n_apply   = 1'b1;
                            n_to      = w_tgt_clamp;
                            n_from    = w_from_in;
                            n_dur_pos = !i_ramp_duration[15] && (i_ramp_duration != '0);
                            n_dur_neg = i_ramp_duration[15];
                            n_is_tick = 1'b0;
                        end
                        msrd_pkg::ACT_DIR: begin
                            n_dir_chg = w_dir_chg;
                            if (w_dir_chg) begin
                                n_pin_a = 1'b0;
                                n_pin_b = 1'b0;
                            end
                        end
                        msrd_pkg::ACT_NOP: ;
                    endcase
                end
            end
            msrd_pkg::S_APPLY: begin
                if (r_apply && (r_cur != r_to)) begin
                    n_ramp = r_dur_neg ? r_ramp : 1'b0;
                    if (r_dur_pos) begin
                        if (w_dist != '0) begin
                            n_cur    = r_from;
                            n_tgt    = r_to;
                            n_period = (w_div_rsp.quotient == '0)
                                     ? msrd_pkg::PERIOD_BITS'(1) : w_div_rsp.quotient;
                            n_ramp   = 1'b1;
                        end
                    end else begin
                        n_duty = r_to;
                        n_cur  = r_to;
                    end
                    if ((n_cur == '0) && r_motor) begin
                        n_motor = 1'b0;
                        n_ramp  = 1'b0;
                    end else if ((r_to != '0) && !r_motor) begin
                        n_motor = 1'b1;
                    end
                end
                if (r_is_tick && r_apply && (n_tgt == n_cur)) begin
                    n_ramp = 1'b0;
                end
            end
            msrd_pkg::S_EMIT0: begin
                if (w_slot_free) begin
                    n_pin_a     = r_dir_req;
                    n_pin_b     = !r_dir_req;
                    n_dir       = r_dir_req;
                    n_dir_known = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msrd_pkg::S_IDLE;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_period    <= '0;
            r_elapsed   <= '0;
            r_ramp      <= 1'b0;
            r_motor     <= 1'b0;
            r_dir       <= 1'b0;
            r_dir_known <= 1'b0;
            r_duty      <= '0;
            r_pin_a     <= 1'b0;
            r_pin_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_period    <= n_period;
            r_elapsed   <= n_elapsed;
            r_ramp      <= n_ramp;
            r_motor     <= n_motor;
            r_dir       <= n_dir;
            r_dir_known <= n_dir_known;
            r_duty      <= n_duty;
            r_pin_a     <= n_pin_a;
            r_pin_b     <= n_pin_b;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_to       <= n_to;
        r_from     <= n_from;
        r_dividend <= n_dividend;
        r_apply    <= n_apply;
        r_dur_pos  <= n_dur_pos;
        r_dur_neg  <= n_dur_neg;
        r_is_tick  <= n_is_tick;
        r_dir_req  <= n_dir_req;
        r_dir_chg  <= n_dir_chg;
        if (w_out_load) begin
            r_o_duty  <= r_duty;
            r_o_pin_a <= r_pin_a;
            r_o_pin_b <= r_pin_b;
            r_o_en    <= !r_motor;
            r_o_ramp  <= r_ramp;
            r_o_hold  <= w_hold;
            r_o_last  <= w_last;
        end
    end

    msrd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_out_valid    = r_out_valid;
    assign o_pwm_duty     = r_o_duty;
    assign o_bridge_pin_a = r_o_pin_a;
    assign o_bridge_pin_b = r_o_pin_b;
    assign o_enable_pin   = r_o_en;
    assign o_ramping      = r_o_ramp;
    assign o_hold_us      = r_o_hold;
    assign o_last         = r_o_last;

`ifndef SYNTHESIS
    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pin_a && r_pin_b))
        else $error("both bridge pins driven high");

    a_first_result_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (!o_bridge_pin_a && !o_bridge_pin_b
                                      && (o_hold_us == msrd_pkg::HOLD_OFF_US)))
        else $error("first direction result not a 600 us off phase");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == msrd_pkg::S_DIV))
        else $error("divider finished outside its wait state");

    a_enable_follows_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_enable_pin == !$past(r_motor)))
        else $error("enable pin does not follow motor status");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/motor_speed_ramp_driver_tb.sv =====
// Self-checking testbench for motor_speed_ramp_driver: directed and random commands,
// a cycle-accurate-free predictor of duty, pins, enable, ramp, hold and last per transaction.
// Depends on msrd_pkg and the motor_speed_ramp_driver RTL.
module motor_speed_ramp_driver_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int RANDOM_ITEMS   = 600;
    localparam int RANDOM_PHASES  = 5;
    localparam int LONG_TICKS     = 100;

    typedef struct packed {
        logic [7:0]                     duty;
        logic                           pin_a;
        logic                           pin_b;
        logic                           pin_en;
        logic                           ramping;
        logic [msrd_pkg::HOLD_BITS-1:0] hold;
        logic                           last;
    } t_bridge_out;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     action = msrd_pkg::ACT_TICK;
    logic signed [15:0]             target_speed = '0;
    logic signed [15:0]             ramp_duration = '0;
    logic signed [8:0]              start_speed = '0;
    logic                           dir_request = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     pwm_duty;
    logic                           bridge_pin_a;
    logic                           bridge_pin_b;
    logic                           enable_pin;
    logic                           ramping;
    logic [msrd_pkg::HOLD_BITS-1:0] hold_us;
    logic                           last;
    logic                           cfg_we = 1'b0;
    logic                           cfg_index = msrd_pkg::CFG_MAX_SPEED;
    logic [7:0]                     cfg_data = '0;

    // predictor state
    logic [7:0]  spd_max = msrd_pkg::MAX_SPEED_RST;
    logic [7:0]  spd_min = msrd_pkg::MIN_SPEED_RST;
    logic [7:0]  speed_now = '0;
    logic [7:0]  speed_goal = '0;
    logic [14:0] step_ms = '0;
    logic [15:0] ms_count = '0;
    logic        ramp_run = 1'b0;
    logic        motor_run = 1'b0;
    logic        dir_cur = 1'b0;
    logic        dir_valid = 1'b0;
    logic [7:0]  duty_now = '0;
    logic        a_lvl = 1'b0;
    logic        b_lvl = 1'b0;
    logic        en_lvl = 1'b1;

    t_bridge_out awaited_outputs[$];
    t_bridge_out want;
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          in_gaps = 1'b1;
    bit          out_stalls = 1'b1;

    motor_speed_ramp_driver dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_target_speed  (target_speed),
        .i_ramp_duration (ramp_duration),
        .i_start_speed   (start_speed),
        .i_dir_request   (dir_request),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_pwm_duty      (pwm_duty),
        .o_bridge_pin_a  (bridge_pin_a),
        .o_bridge_pin_b  (bridge_pin_b),
        .o_enable_pin    (enable_pin),
        .o_ramping       (ramping),
        .o_hold_us       (hold_us),
        .o_last          (last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_outputs(logic [msrd_pkg::HOLD_BITS-1:0] hold, logic is_last);
        t_bridge_out r;
        r.duty    = duty_now;
        r.pin_a   = a_lvl;
        r.pin_b   = b_lvl;
        r.pin_en  = en_lvl;
        r.ramping = ramp_run;
        r.hold    = hold;
        r.last    = is_last;
        awaited_outputs.push_back(r);
    endfunction

    function automatic void apply_speed(int tgt, int dur, int st);
        int from_spd;
        int to_spd;
        int spd_delta;
        int per;
        if (tgt > int'(spd_max)) tgt = spd_max;
        if (tgt < 0) tgt = spd_min;
        to_spd = tgt & 8'hFF;
        from_spd = (st < 0) ? int'(speed_now) : (st & 8'hFF);
        if (int'(speed_now) == to_spd) return;
        if (dur >= 0) ramp_run = 1'b0;
        if (dur > 0) begin
            spd_delta = (to_spd > from_spd) ? to_spd - from_spd : from_spd - to_spd;
            if (spd_delta != 0) begin
                speed_now  = from_spd[7:0];
                speed_goal = to_spd[7:0];
                per = dur / spd_delta;
                if (per < 1) per = 1;
                step_ms  = per[14:0];
                ramp_run = 1'b1;
            end
        end else begin
            duty_now  = to_spd[7:0];
            speed_now = to_spd[7:0];
        end
        if (speed_now == 8'd0 && motor_run) begin
            motor_run = 1'b0;
            ramp_run  = 1'b0;
            en_lvl    = 1'b1;
        end else if (to_spd != 0 && !motor_run) begin
            motor_run = 1'b1;
            en_lvl    = 1'b0;
        end
    endfunction

    function automatic void step_ramp_tick();
        int s;
        if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
        if (ramp_run && ms_count >= {1'b0, step_ms}) begin
            s = speed_now;
            ms_count = '0;
            if (speed_goal > speed_now) s = s + 1;
            else if (speed_goal < speed_now) s = s - 1;
            apply_speed(s, -1, -1);
            if (speed_goal == speed_now) ramp_run = 1'b0;
        end
    endfunction

    function automatic void predict_bridge(msrd_pkg::t_action act, logic signed [15:0] tsp,
                                           logic signed [15:0] dur, logic signed [8:0] st,
                                           logic dr);
        case (act)
            msrd_pkg::ACT_TICK: begin
                step_ramp_tick();
                push_outputs(msrd_pkg::HOLD_NONE, 1'b1);
            end
            msrd_pkg::ACT_SPEED: begin
                apply_speed(int'(tsp), int'(dur), int'(st));
                push_outputs(msrd_pkg::HOLD_NONE, 1'b1);
            end
            msrd_pkg::ACT_DIR: begin
                if (!dir_valid || dir_cur != dr) begin
                    a_lvl = 1'b0;
                    b_lvl = 1'b0;
                    push_outputs(msrd_pkg::HOLD_OFF_US, 1'b0);
                    if (dr) a_lvl = 1'b1;
                    else b_lvl = 1'b1;
                    dir_cur   = dr;
                    dir_valid = 1'b1;
                    push_outputs(msrd_pkg::HOLD_ON_US, 1'b1);
                end else begin
                    push_outputs(msrd_pkg::HOLD_NONE, 1'b1);
                end
            end
            default: push_outputs(msrd_pkg::HOLD_NONE, 1'b1);
        endcase
    endfunction

    task automatic send_cmd(msrd_pkg::t_action act, logic signed [15:0] tsp,
                            logic signed [15:0] dur, logic signed [8:0] st, logic dr);
        int gap;
        gap = (in_gaps && $urandom_range(0, 1)) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        action        <= act;
        target_speed  <= tsp;
        ramp_duration <= dur;
        start_speed   <= st;
        dir_request   <= dr;
        do @(posedge clk); while (!(in_valid && in_ready));
        predict_bridge(act, tsp, dur, st, dr);
    endtask

    task automatic send_simple(msrd_pkg::t_action act, logic dr);
        send_cmd(act, 16'($urandom), 16'($urandom), 9'($urandom), dr);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_outputs.size() > 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(msrd_pkg::t_cfg_index idx, logic [7:0] val);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == msrd_pkg::CFG_MAX_SPEED) spd_max = val;
        else spd_min = val;
    endtask

    task automatic send_random();
        msrd_pkg::t_action  act;
        logic signed [15:0] tsp;
        logic signed [15:0] dur;
        logic signed [8:0]  st;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 55) act = msrd_pkg::ACT_TICK;
        else if (r < 82) act = msrd_pkg::ACT_SPEED;
        else if (r < 96) act = msrd_pkg::ACT_DIR;
        else act = msrd_pkg::ACT_NOP;
        r = $urandom_range(0, 99);
        if (r < 60) tsp = 16'($urandom_range(0, 300));
        else if (r < 75) tsp = -16'($urandom_range(1, 5));
        else if (r < 85) tsp = '0;
        else tsp = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) dur = '0;
        else if (r < 30) dur = -16'($urandom_range(1, 32768));
        else if (r < 80) dur = 16'($urandom_range(1, 100));
        else if (r < 90) dur = 16'($urandom_range(100, 2000));
        else dur = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50) st = -9'sd1;
        else if (r < 85) st = 9'($urandom_range(0, 255));
        else st = 9'($urandom);
        send_cmd(act, tsp, dur, st, 1'($urandom));
    endtask

    task automatic test_direction();
        send_simple(msrd_pkg::ACT_TICK, 1'b0);
        send_simple(msrd_pkg::ACT_DIR, 1'b0);
        send_simple(msrd_pkg::ACT_DIR, 1'b0);
        send_simple(msrd_pkg::ACT_DIR, 1'b1);
        send_cmd(msrd_pkg::ACT_NOP, 16'hFFFF, 16'hFFFF, 9'h1FF, 1'b1);
    endtask

    task automatic test_sharp_speed();
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd255, 16'sd0, -9'sd1, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd255, -16'sd5, 9'sd0, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sh7FFF, 16'sh8000, 9'sd255, 1'b1);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sh8000, 16'sd0, -9'sd1, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd0, 16'sd0, 9'sd255, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd1, -16'sd1, -9'sd256, 1'b1);
    endtask

    task automatic test_ramp();
        int n;
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd10, 16'sd0, -9'sd1, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd200, 16'sd1, -9'sd1, 1'b0);
        repeat (3) send_simple(msrd_pkg::ACT_TICK, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd50, 16'sd100, 9'sd50, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd0, 16'sh7FFF, 9'sd255, 1'b0);
        send_simple(msrd_pkg::ACT_TICK, 1'b1);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd5, 16'sd20, 9'sd0, 1'b0);
        n = 0;
        while (ramp_run && n < 30) begin
            send_simple(msrd_pkg::ACT_TICK, 1'b0);
            n++;
        end
    endtask

    task automatic test_limits();
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd250, 16'sd250, 9'sd100, 1'b0);
        repeat (5) send_simple(msrd_pkg::ACT_TICK, 1'b0);
        write_reg(msrd_pkg::CFG_MAX_SPEED, speed_now);
        repeat (4) send_simple(msrd_pkg::ACT_TICK, 1'b0);
        write_reg(msrd_pkg::CFG_MAX_SPEED, 8'd3);
        write_reg(msrd_pkg::CFG_MIN_SPEED, 8'd255);
        send_cmd(msrd_pkg::ACT_SPEED, -16'sd1, 16'sd0, -9'sd1, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd200, 16'sd0, -9'sd1, 1'b0);
        write_reg(msrd_pkg::CFG_MAX_SPEED, msrd_pkg::MAX_SPEED_RST);
        write_reg(msrd_pkg::CFG_MIN_SPEED, msrd_pkg::MIN_SPEED_RST);
    endtask

    task automatic test_tick_backlog();
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd20, 16'sd0, -9'sd1, 1'b0);
        repeat (LONG_TICKS) send_simple(msrd_pkg::ACT_TICK, 1'b0);
        send_cmd(msrd_pkg::ACT_SPEED, 16'sd30, 16'sd500, -9'sd1, 1'b0);
        send_simple(msrd_pkg::ACT_TICK, 1'b0);
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
    endtask

    task automatic test_random();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(msrd_pkg::CFG_MAX_SPEED, 8'd255);
                    write_reg(msrd_pkg::CFG_MIN_SPEED, 8'd0);
                end
                1: begin
                    write_reg(msrd_pkg::CFG_MAX_SPEED, 8'd1);
                    write_reg(msrd_pkg::CFG_MIN_SPEED, 8'd0);
                end
                2: begin
                    write_reg(msrd_pkg::CFG_MAX_SPEED, 8'd255);
                    write_reg(msrd_pkg::CFG_MIN_SPEED, 8'd255);
                end
                3: begin
                    write_reg(msrd_pkg::CFG_MAX_SPEED, 8'd100);
                    write_reg(msrd_pkg::CFG_MIN_SPEED, 8'd30);
                end
                default: begin
                    write_reg(msrd_pkg::CFG_MAX_SPEED, 8'($urandom_range(1, 255)));
                    write_reg(msrd_pkg::CFG_MIN_SPEED, 8'($urandom_range(0, 255)));
                end
            endcase
            in_gaps    = ($urandom_range(0, 4) != 0);
            out_stalls = ($urandom_range(0, 4) != 0);
            repeat (RANDOM_ITEMS / RANDOM_PHASES) send_random();
        end
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (out_stalls && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap() - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (awaited_outputs.size() == 0) begin
                $error("output transaction with none expected");
                fail_count++;
            end else begin
                want = awaited_outputs.pop_front();
                if (pwm_duty !== want.duty) begin
                    $error("pwm_duty: expected %0d, got %0d", want.duty, pwm_duty);
                    fail_count++;
                end
                if (bridge_pin_a !== want.pin_a) begin
                    $error("bridge_pin_a: expected %0b, got %0b", want.pin_a, bridge_pin_a);
                    fail_count++;
                end
                if (bridge_pin_b !== want.pin_b) begin
                    $error("bridge_pin_b: expected %0b, got %0b", want.pin_b, bridge_pin_b);
                    fail_count++;
                end
                if (enable_pin !== want.pin_en) begin
                    $error("enable_pin: expected %0b, got %0b", want.pin_en, enable_pin);
                    fail_count++;
                end
                if (ramping !== want.ramping) begin
                    $error("ramping: expected %0b, got %0b", want.ramping, ramping);
                    fail_count++;
                end
                if (hold_us !== want.hold) begin
                    $error("hold_us: expected %0d, got %0d", want.hold, hold_us);
                    fail_count++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_direction();
        test_sharp_speed();
        test_ramp();
        test_limits();
        test_tick_backlog();
        test_random();
        settle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
